### sv/sau_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the sigmoid activation unit.
// No dependencies; used by every module of the block.
package sau_pkg;

  localparam int X_W          = 16;   // signed Q4.12 input
  localparam int SIG_W        = 16;   // unsigned Q0.16 sigmoid
  localparam int DER_W        = 15;   // unsigned Q0.16 derivative
  localparam int Y_W          = 30;   // reduced exponent argument, Q30
  localparam int P_W          = 31;   // series value, Q30, up to 1.0
  localparam int NUM_W        = 47;   // dividend of the final division
  localparam int DEN_W        = 32;   // divisor, 1.0 + e^-|x| in Q30
  localparam int QUO_W        = 17;   // quotient, up to 65536
  localparam int REM_W        = 31;
  localparam int HORNER_TERMS = 7;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [46:0] Q46_ONE   = 47'h4000_0000_0000;
  localparam logic [46:0] T_ROUND   = 47'h0000_0200_0000;

  // floor(2^31 / k) for the series divisors; entry zero is never used.
  localparam logic [31:0] RECIP_Q31 [8] = '{
    32'd0,
    32'd2147483648,
    32'd1073741824,
    32'd715827882,
    32'd536870912,
    32'd429496729,
    32'd357913941,
    32'd306783378
  };

  // Per-item data that rides alongside the exponent series.
  typedef struct packed {
    logic       neg;
    logic [3:0] shift;
  } sau_side_t;

endpackage

### sv/sau_exp_unit.sv
`timescale 1ns / 1ps
// Pipelined Horner evaluation of e^-y for 0 <= y < ln2, Q30 in and out.
// Depends on sau_pkg. Three register stages per series term.
module sau_exp_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sau_pkg::Y_W-1:0]   y_in,
  input  sau_pkg::sau_side_t        side_in,
  output logic                      out_valid,
  output logic [sau_pkg::P_W-1:0]   p_out,
  output sau_pkg::sau_side_t        side_out
);

  localparam int NT = sau_pkg::HORNER_TERMS;

  logic                    vld_c  [NT+1];
  logic [sau_pkg::P_W-1:0] p_c    [NT+1];
  sau_pkg::sau_side_t      side_c [NT+1];
  logic [sau_pkg::Y_W-1:0] y_c    [NT];

  assign vld_c[0]  = in_valid;
  assign p_c[0]    = sau_pkg::Q30_ONE;
  assign side_c[0] = side_in;
  assign y_c[0]    = y_in;

  genvar i;
  for (i = 0; i < NT; i++) begin : g_term
    localparam logic [2:0]  K = 3'(NT - i);
    localparam logic [31:0] M = sau_pkg::RECIP_Q31[NT - i];

    logic                    vld_a, vld_b, vld_o;
    sau_pkg::sau_side_t      side_a, side_b, side_o;
    logic [29:0]             x_a, x_b, q0_b;
    logic [sau_pkg::P_W-1:0] p_o;
    logic [60:0]             prod;
    logic [61:0]             qm;
    logic [32:0]             kq;
    logic [29:0]             rem;
    logic [29:0]             quo;

    // Stage A: y * p, kept as (y * p) >> 30.
    assign prod = y_c[i] * p_c[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a <= 1'b0;
      end else if (en) begin
        vld_a <= vld_c[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_a <= side_c[i];
        x_a    <= prod[59:30];
      end
    end

    // Stage B: estimate of x / k by reciprocal; at most one short.
    assign qm = x_a * M;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_b <= 1'b0;
      end else if (en) begin
        vld_b <= vld_a;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_b <= side_a;
        x_b    <= x_a;
        q0_b   <= qm[60:31];
      end
    end

    // Stage C: correct the estimate and form the next series value.
    assign kq  = q0_b * K;
    assign rem = x_b - kq[29:0];
    assign quo = q0_b + 30'(rem >= {27'd0, K});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_o <= 1'b0;
      end else if (en) begin
        vld_o <= vld_b;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_o <= side_b;
        p_o    <= sau_pkg::Q30_ONE - {1'b0, quo};
      end
    end

    assign vld_c[i+1]  = vld_o;
    assign p_c[i+1]    = p_o;
    assign side_c[i+1] = side_o;

    if (i < NT - 1) begin : g_fwd
      logic [sau_pkg::Y_W-1:0] y_a, y_b, y_o;

      always_ff @(posedge clk) begin
        if (en) begin
          y_a <= y_c[i];
          y_b <= y_a;
          y_o <= y_b;
        end
      end

      assign y_c[i+1] = y_o;
    end
  end

  assign out_valid = vld_c[NT];
  assign p_out     = p_c[NT];
  assign side_out  = side_c[NT];

endmodule

### sv/sau_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on sau_pkg. The quotient must be below 2^17 for the given operands.
module sau_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sau_pkg::NUM_W-1:0] num,
  input  logic [sau_pkg::DEN_W-1:0] den,
  output logic                      out_valid,
  output logic [sau_pkg::QUO_W-1:0] quo
);

  localparam int NS = sau_pkg::QUO_W;

  logic                      vld_c [NS+1];
  logic [sau_pkg::QUO_W-1:0] quo_c [NS+1];
  logic [sau_pkg::REM_W-1:0] rem_c [NS];
  logic [sau_pkg::QUO_W-1:0] low_c [NS];
  logic [sau_pkg::DEN_W-1:0] den_c [NS];

  // The top bits of the dividend are already below the divisor.
  assign vld_c[0] = in_valid;
  assign quo_c[0] = '0;
  assign rem_c[0] = {1'b0, num[sau_pkg::NUM_W-1:sau_pkg::QUO_W]};
  assign low_c[0] = num[sau_pkg::QUO_W-1:0];
  assign den_c[0] = den;

  genvar j;
  for (j = 0; j < NS; j++) begin : g_bit
    logic                      vld_o;
    logic [sau_pkg::QUO_W-1:0] quo_o;
    logic [31:0]               trial;
    logic                      fits;

    assign trial = {rem_c[j], low_c[j][sau_pkg::QUO_W-1]};
    assign fits  = trial >= den_c[j];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_o <= 1'b0;
      end else if (en) begin
        vld_o <= vld_c[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_o <= {quo_c[j][sau_pkg::QUO_W-2:0], fits};
      end
    end

    assign vld_c[j+1] = vld_o;
    assign quo_c[j+1] = quo_o;

    if (j < NS - 1) begin : g_fwd
      logic [sau_pkg::REM_W-1:0] rem_o;
      logic [sau_pkg::QUO_W-1:0] low_o;
      logic [sau_pkg::DEN_W-1:0] den_o;
      logic [31:0]               diff;

      assign diff = trial - den_c[j];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_o <= fits ? diff[sau_pkg::REM_W-1:0] : trial[sau_pkg::REM_W-1:0];
          low_o <= {low_c[j][sau_pkg::QUO_W-2:0], 1'b0};
          den_o <= den_c[j];
        end
      end

      assign rem_c[j+1] = rem_o;
      assign low_c[j+1] = low_o;
      assign den_c[j+1] = den_o;
    end
  end

  assign out_valid = vld_c[NS];
  assign quo       = quo_c[NS];

endmodule

### sv/sigmoid_activation_unit.sv
`timescale 1ns / 1ps
// Logistic sigmoid and its derivative on a stream of Q4.12 activations.
// One item per cycle while no result waits at the output.
// The rate is set by the fully pipelined 21-stage exponent series and the
// 17-stage divider; the whole pipeline advances together and holds while a
// result waits. Synchronous active-high reset clears all stage valid bits.
// Depends on sau_pkg, sau_exp_unit and sau_divider.
module sigmoid_activation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] x_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] sigmoid_out, [30:16] derivative_out
);

  logic en;

  logic                      vld1, vld2, vld3, vld4, vld5, vld6, vld7, vld8, vld9;
  logic                      neg1, neg2, neg3, neg5;
  logic [15:0]               a1;
  logic [46:0]               t_prod2;
  logic [46:0]               t_rnd;
  logic [3:0]                n3;
  logic [15:0]               f3;
  logic [45:0]               y_prod;
  logic [sau_pkg::Y_W-1:0]   y4;
  sau_pkg::sau_side_t        side4;
  logic                      vld_e;
  logic [sau_pkg::P_W-1:0]   p_e;
  sau_pkg::sau_side_t        side_e;
  logic [sau_pkg::P_W-1:0]   e5;
  logic [sau_pkg::DEN_W-1:0] d_c;
  logic [sau_pkg::NUM_W-1:0] num_c;
  logic [sau_pkg::NUM_W-1:0] num6;
  logic [sau_pkg::DEN_W-1:0] d6;
  logic                      vld_q;
  logic [sau_pkg::QUO_W-1:0] quo_q;
  logic [sau_pkg::SIG_W-1:0] s7, s8, s9;
  logic [16:0]               one_minus;
  logic [32:0]               d_prod;
  logic [30:0]               dp8;
  logic [31:0]               d_sum;
  logic [sau_pkg::DER_W-1:0] der9;

  // The pipeline moves whenever the output register is free or being taken.
  assign en            = !vld9 || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
      vld7 <= 1'b0;
      vld8 <= 1'b0;
      vld9 <= 1'b0;
    end else if (en) begin
      vld1 <= s_axis_tvalid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld_e;
      vld6 <= vld5;
      vld7 <= vld_q;
      vld8 <= vld7;
      vld9 <= vld8;
    end
  end

  // Front end: magnitude, scale by log2(e), split into shift and fraction, scale fraction by ln2.
  assign t_rnd  = t_prod2 + sau_pkg::T_ROUND;
  assign y_prod = f3 * sau_pkg::LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1        <= s_axis_tdata[15];
      a1          <= s_axis_tdata[15] ? 16'(~s_axis_tdata + 16'd1) : s_axis_tdata;
      neg2        <= neg1;
      t_prod2     <= a1 * sau_pkg::LOG2E_Q30;
      neg3        <= neg2;
      n3          <= t_rnd[45:42];
      f3          <= t_rnd[41:26];
      side4.neg   <= neg3;
      side4.shift <= n3;
      y4          <= y_prod[45:16];
    end
  end

  sau_exp_unit u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld4),
    .y_in      (y4),
    .side_in   (side4),
    .out_valid (vld_e),
    .p_out     (p_e),
    .side_out  (side_e)
  );

  // Scale the series by 2^-n, then build dividend and divisor.
  assign d_c   = {1'b0, sau_pkg::Q30_ONE} + {1'b0, e5};
  assign num_c = (neg5 ? {e5, 16'd0} : sau_pkg::Q46_ONE) + 47'(d_c[31:1]);

  always_ff @(posedge clk) begin
    if (en) begin
      e5   <= p_e >> side_e.shift;
      neg5 <= side_e.neg;
      num6 <= num_c;
      d6   <= d_c;
    end
  end

  sau_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld6),
    .num       (num6),
    .den       (d6),
    .out_valid (vld_q),
    .quo       (quo_q)
  );

  // Saturate, then derivative s * (1 - s) with rounding.
  assign one_minus = 17'h1_0000 - {1'b0, s7};
  assign d_prod    = s7 * one_minus;
  assign d_sum     = {1'b0, dp8} + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (en) begin
      s7   <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
      s8   <= s7;
      dp8  <= d_prod[30:0];
      s9   <= s8;
      der9 <= d_sum[30:16];
    end
  end

  assign m_axis_tvalid = vld9;
  assign m_axis_tdata  = {1'b0, der9, s9};

  // The scaled magnitude never overflows and the shift stays at most 11.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    vld2 |-> (!t_rnd[46] && t_rnd[45:42] <= 4'd11))
    else $error("exponent shift out of range");

  // The divider never produces a quotient above 1.0 in Q0.16.
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    vld_q |-> quo_q <= 17'h1_0000)
    else $error("sigmoid quotient above one");

  // A held result keeps the pipeline frozen, checked here on vld4, vld6 and vld8.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(vld4) && $stable(vld6) && $stable(vld8)))
    else $error("pipeline moved during a stall");

  // The derivative of the logistic function cannot exceed one quarter.
  a_der_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[30:16] <= 15'd16384)
    else $error("derivative above one quarter");

endmodule

### tb/sigmoid_activation_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sigmoid_activation_unit: a stream of Q4.12 activations
// checked against a bit-exact fixed-point sigmoid and derivative predictor.
// Depends only on the RTL of the block (sau_pkg and its submodules).
module sigmoid_activation_unit_tb;

  localparam longint unsigned ONE_Q30   = 64'd1 << 30;
  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam int              SERIES_ORDER = 7;
  localparam int              PIPE_LATENCY = 47;
  localparam int              IDLE_PCT     = 21;
  localparam int              RANDOM_ITEMS = 1200;
  localparam int              HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [14:0] derivative;
    logic [15:0] sigmoid;
  } sigmoid_pair_t;

  class sau_scoreboard;
    sigmoid_pair_t pending_q[$];
    int            errors;
    int            accepted;
    int            checked;

    // Bit-exact sigmoid and derivative of one signed Q4.12 activation.
    function sigmoid_pair_t predict(logic [15:0] x);
      longint unsigned mag, t, n, f, y, p, e, d, s, der;
      sigmoid_pair_t   r;
      mag = x[15] ? (64'h10000 - {48'b0, x}) : {48'b0, x};
      t   = (mag * LOG2E_Q30 + (64'd1 << 25)) >> 26;
      n   = t >> 16;
      f   = t & 64'hFFFF;
      y   = (f * LN2_Q30) >> 16;
      // Horner evaluation of the truncated series for e^-y.
      p = ONE_Q30;
      for (int k = SERIES_ORDER; k >= 1; k--)
        p = ONE_Q30 - ((y * p) >> 30) / k;
      e = (n < 32) ? (p >> n) : 64'd0;
      d = ONE_Q30 + e;
      if (x[15])
        s = ((e << 16) + (d >> 1)) / d;
      else
        s = ((64'd1 << 46) + (d >> 1)) / d;
      if (s > 64'd65535)
        s = 64'd65535;
      der = (s * (64'd65536 - s) + 64'd32768) >> 16;
      r.sigmoid    = s[15:0];
      r.derivative = der[14:0];
      return r;
    endfunction

    function void note_input(logic [15:0] x);
      pending_q.push_back(predict(x));
      accepted++;
    endfunction

    function void check_result(logic [31:0] data);
      sigmoid_pair_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (data[15:0] !== want.sigmoid) begin
        errors++;
        $display("%0t: sigmoid_out mismatch, expected %0d, actual %0d",
                 $time, want.sigmoid, data[15:0]);
      end
      if (data[30:16] !== want.derivative) begin
        errors++;
        $display("%0t: derivative_out mismatch, expected %0d, actual %0d",
                 $time, want.derivative, data[30:16]);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [15:0] x_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // [15:0] sigmoid_out, [30:16] derivative_out

  sau_scoreboard activation_sb;
  int            items_sent;
  bit            sender_steady;
  bit            hold_done;

  sigmoid_activation_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offers one activation, with random idle cycles beforehand unless the sender is steady, and waits for its transfer.
  task automatic send_activation(input logic [15:0] x);
    while (!sender_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    activation_sb.note_input(x);
    items_sent++;
  endtask

  // Result side: random stalls, a quiet window, and one long hold-off so the pipeline fills.
  initial begin
    int cyc;
    int hold_left;
    cyc           = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && items_sent >= 800) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (cyc >= 1500 && cyc < 2000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      activation_sb.check_result(m_axis_tdata);
  end

  initial begin
    logic [15:0] directed [$];
    logic [15:0] x;
    activation_sb = new();
    items_sent    = 0;
    sender_steady = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, the unit steps, the range ends (0x8000 is -8.0) and a few mid-range values.
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                 16'h7FFE, 16'h1000, 16'hF000, 16'h4000, 16'hC000, 16'h0800,
                 16'hF800, 16'h5555, 16'hAAAA, 16'h2000, 16'hE000, 16'h0B17,
                 16'hF4E9, 16'h6000, 16'hA000};
    foreach (directed[i])
      send_activation(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_steady = (i >= 400 && i < 600);
      if ($urandom_range(0, 9) < 7)
        x = 16'($urandom_range(0, 65535));
      else
        x = 16'($urandom_range(0, 16383) - 8192);
      send_activation(x);
    end
    s_axis_tvalid <= 1'b0;

    while (activation_sb.pending() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    $display("Sent %0d activations over the full Q4.12 range; %0d results checked,",
             activation_sb.accepted, activation_sb.checked);
    $display("with random stalls on both sides and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (activation_sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", activation_sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
sv/sau_pkg.sv
sv/sau_exp_unit.sv
sv/sau_divider.sv
sv/sigmoid_activation_unit.sv
tb/sigmoid_activation_unit_tb.sv
